@@ rtl/core/caq_pkg.sv @@
// caq_pkg: shared types, codes and sizes for the circular array queue
// used by caq_ctrl, caq_dp and circular_array_queue_unit; no dependencies
package caq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int CAP_W  = 5;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;
  localparam int WORD_W = 32;

  localparam logic [CAP_W-1:0] MIN_CAPACITY = 5'd5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FRDEQ = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] value;
  } caq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic [CAP_W-1:0]         count;
    logic                     is_empty;
    logic                     is_full;
  } caq_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic issue;   // latch request and read the front entry
    logic exec;    // apply the request and load the result register
    logic cfg_wr;  // write capacity and empty the queue
  } caq_cmd_t;

endpackage

@@ rtl/core/caq_ctrl.sv @@
// caq_ctrl: sequencing of requests, handshakes and result valid
// depends on caq_pkg
module caq_ctrl
  import caq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output caq_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic can_load;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign can_load  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.cfg_wr = cfg_valid && cfg_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.issue  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_load) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // a result is never loaded over one that was not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");
  // a request leaves the idle state only through execution
  a_issue_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |=> state == S_EXEC)
    else $error("accepted request not executed");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.cfg_wr |-> !cmd.exec && !cmd.issue)
    else $error("capacity write during a request");
`endif

endmodule

@@ rtl/core/caq_dp.sv @@
// caq_dp: ring store, head/tail/count registers, capacity and result register
// depends on caq_pkg; driven by caq_ctrl commands
module caq_dp
  import caq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  caq_cmd_t         cmd,
  input  caq_in_t          in_item,
  input  logic [CAP_W-1:0] cfg_data,
  output caq_out_t         out_item
);

  localparam int IW = $clog2(DEPTH);
  localparam int WW = ((IW > CAP_W) ? IW : CAP_W) + 1;
  localparam int CAP_LIM = (DEPTH > 31) ? 31 : DEPTH;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(CAP_LIM);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [CMD_W-1:0]      cmd_q;
  logic [WORD_W-1:0]     value_q;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [IW-1:0]         head;
  logic [IW-1:0]         tail;
  logic [CAP_W-1:0]      count;
  logic [CAP_W-1:0]      capacity;

  logic [IW-1:0]     head_next;
  logic [IW-1:0]     tail_next;
  logic [CAP_W-1:0]  count_next;
  logic [CAP_W-1:0]  cap_new;
  logic [STAT_W-1:0] status;
  logic [WORD_W-1:0] data;
  logic              wr_en;
  logic [63:0]       rd_wide;
  logic [63:0]       val_wide;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
                                             input logic [CAP_W-1:0] cap);
    logic [WW-1:0] sum;
    sum = WW'(idx) + WW'(1);
    if (sum >= WW'(cap)) begin
      return '0;
    end
    return sum[IW-1:0];
  endfunction

  assign rd_wide  = 64'(rd_data);
  assign val_wide = 64'(value_q);

  always_comb begin
    cap_new = cfg_data;
    if (cfg_data < MIN_CAPACITY) begin
      cap_new = MIN_CAPACITY;
    end else if (cfg_data > CAP_MAX) begin
      cap_new = CAP_MAX;
    end
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    status     = ST_OK;
    data       = '0;
    wr_en      = 1'b0;
    unique case (cmd_q) inside
      CMD_ENQ: begin
        if (count >= capacity) begin
          status = ST_FULL;
        end else begin
          count_next = count + CAP_W'(1);
          tail_next  = wrap_inc(tail, capacity);
          wr_en      = 1'b1;
        end
      end
      CMD_DEQ, CMD_PEEK, CMD_FRDEQ: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          if (cmd_q != CMD_DEQ) begin
            data = rd_wide[WORD_W-1:0];
          end
          if (cmd_q != CMD_PEEK) begin
            head_next  = wrap_inc(head, capacity);
            count_next = count - CAP_W'(1);
          end
        end
      end
      CMD_CLEAR: begin
        head_next  = IW'(1);
        tail_next  = '0;
        count_next = '0;
      end
      default: ;
    endcase
  end

  // ring store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[tail_next] <= val_wide[DATA_WIDTH-1:0];
    end
    if (cmd.issue) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      cmd_q   <= in_item.command;
      value_q <= in_item.value;
    end
    if (cmd.exec) begin
      out_item.data     <= data;
      out_item.status   <= status;
      out_item.count    <= count_next;
      out_item.is_empty <= (count_next == '0);
      out_item.is_full  <= (count_next == capacity);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= IW'(1);
      tail     <= '0;
      count    <= '0;
      capacity <= CAP_MAX;
    end else if (cmd.cfg_wr) begin
      capacity <= cap_new;
      head     <= IW'(1);
      tail     <= '0;
      count    <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= capacity)
    else $error("element count above capacity");
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    WW'(head) < WW'(capacity) && WW'(tail) < WW'(capacity))
    else $error("ring index beyond capacity");
  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && cmd_q == CMD_ENQ && count < capacity |=>
    count == $past(count) + CAP_W'(1))
    else $error("enqueue did not grow the count");
  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && status != ST_OK |=> $stable(head) && $stable(tail) && $stable(count))
    else $error("refused request changed the queue");
`endif

endmodule

@@ rtl/core/circular_array_queue_unit.sv @@
// circular_array_queue_unit: top level of the circular array queue
// depends on caq_pkg, caq_ctrl and caq_dp
//
//  channel | signals                         | payload
//  in      | in_valid / in_ready             | in_item (command, value)
//  out     | out_valid / out_ready           | out_item (data, status, count, flags)
//  cfg     | cfg_valid / cfg_ready           | cfg_data (capacity)
//
// each request is accepted with the front-entry read, then executed
// the separate execute step comes from the registered read port of the ring store
// a new request is accepted while the previous result waits in the output register
// execution stalls while the output register is still full and out_ready is low
// rst synchronously returns indices, count and capacity to their reset values; the store needs no clearing
module circular_array_queue_unit
  import caq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  caq_in_t          in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output caq_out_t         out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  caq_cmd_t cmd;

  caq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  caq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_data (cfg_data),
    .out_item (out_item)
  );

endmodule
